### hdl/assert_macros.svh
// Assertion macros shared by the byte match ratio modules.
// Each use expects i_clk and i_rst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define BMR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define BMR_IMPLY_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bmr_pkg.sv
// Shared types and constants for the byte match ratio block.
// No dependencies; imported by every module of the block.
package bmr_pkg;

    localparam int Q_BITS  = 17;   // Q1.16 similarity width
    localparam int STEP_W  = 5;    // holds a step index 0..Q_BITS-1
    localparam int FIELD_W = 16;   // width of the count fields on the ports

    localparam logic [Q_BITS-1:0] Q_ONE = 17'h10000;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

    // Divider status as seen by the top level.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### hdl/bmr_count.sv
// Saturating match and length counters for the byte match ratio block.
// Depends on bmr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bmr_count
    import bmr_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [7:0]             i_byte_first,
    input  logic                   i_has_first,
    input  logic [7:0]             i_byte_second,
    input  logic                   i_has_second,
    input  logic                   i_is_last,
    output logic                   o_start,
    output logic [LENGTH_BITS-1:0] o_match,
    output logic [LENGTH_BITS-1:0] o_len_first,
    output logic [LENGTH_BITS-1:0] o_len_second
);

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

    logic [LENGTH_BITS-1:0] r_match, r_len_first, r_len_second;
    logic [LENGTH_BITS-1:0] n_match, n_len_first, n_len_second;

    function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + LENGTH_BITS'(1);
    endfunction

    always_comb begin
        n_match      = r_match;
        n_len_first  = r_len_first;
        n_len_second = r_len_second;
        if (i_accept) begin
            if (i_has_first) begin
                n_len_first = sat_inc(r_len_first);
            end
            if (i_has_second) begin
                n_len_second = sat_inc(r_len_second);
            end
            if (i_has_first && i_has_second && (i_byte_first == i_byte_second)) begin
                n_match = sat_inc(r_match);
            end
        end
    end

    // The counts including the last item go straight to the divider.
    assign o_start      = i_accept && i_is_last;
    assign o_match      = n_match;
    assign o_len_first  = n_len_first;
    assign o_len_second = n_len_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_start) begin
            r_match      <= '0;
            r_len_first  <= '0;
            r_len_second <= '0;
        end else begin
            r_match      <= n_match;
            r_len_first  <= n_len_first;
            r_len_second <= n_len_second;
        end
    end

    `BMR_ASSERT(a_match_bounded,
        ((r_match <= r_len_first) && (r_match <= r_len_second)),
        "match count exceeds a sequence length")

endmodule

### hdl/bmr_div.sv
// Bit-serial restoring divider forming matches / longer length in Q1.16.
// Depends on bmr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bmr_div
    import bmr_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [LENGTH_BITS-1:0] i_match,
    input  logic [LENGTH_BITS-1:0] i_len_first,
    input  logic [LENGTH_BITS-1:0] i_len_second,
    input  logic                   i_take,
    output t_div_stat              o_stat,
    output logic [Q_BITS-1:0]      o_quot,
    output logic [LENGTH_BITS-1:0] o_match,
    output logic [LENGTH_BITS-1:0] o_longer
);

    t_div_state r_state, n_state;

    logic [LENGTH_BITS:0]   r_rem, n_rem;
    logic [LENGTH_BITS-1:0] r_div, n_div;
    logic [LENGTH_BITS-1:0] r_match, n_match;
    logic [Q_BITS-1:0]      r_quot, n_quot;
    logic [STEP_W-1:0]      r_step, n_step;

    logic [LENGTH_BITS-1:0] longer;
    logic                   q_bit;
    logic [LENGTH_BITS:0]   rem_sel;

    assign longer = (i_len_first > i_len_second) ? i_len_first : i_len_second;

    // One quotient bit per cycle: compare, conditionally subtract, shift.
    assign q_bit   = (r_rem >= {1'b0, r_div});
    assign rem_sel = q_bit ? (r_rem - {1'b0, r_div}) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_div   = r_div;
        n_match = r_match;
        n_quot  = r_quot;
        n_step  = r_step;
        unique case (r_state)
            DIV_IDLE: begin
                if (i_start) begin
                    n_div   = longer;
                    n_match = i_match;
                    n_rem   = {1'b0, i_match};
                    n_step  = '0;
                    if (i_len_first == '0 && i_len_second == '0) begin
                        n_quot  = Q_ONE;
                        n_match = '0;
                        n_state = DIV_DONE;
                    end else if (i_len_first == '0 || i_len_second == '0) begin
                        n_quot  = '0;
                        n_match = '0;
                        n_state = DIV_DONE;
                    end else begin
                        n_quot  = '0;
                        n_state = DIV_RUN;
                    end
                end
            end
            DIV_RUN: begin
                n_quot = {r_quot[Q_BITS-2:0], q_bit};
                n_rem  = {rem_sel[LENGTH_BITS-1:0], 1'b0};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(Q_BITS - 1)) begin
                    n_state = DIV_DONE;
                end
            end
            DIV_DONE: begin
                if (i_take) begin
                    n_state = DIV_IDLE;
                end
            end
            default: begin
                n_state = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_div   <= n_div;
        r_match <= n_match;
        r_quot  <= n_quot;
        r_step  <= n_step;
    end

    assign o_stat.busy = (r_state != DIV_IDLE);
    assign o_stat.done = (r_state == DIV_DONE);
    assign o_quot      = r_quot;
    assign o_match     = r_match;
    assign o_longer    = r_div;

    `BMR_ASSERT(a_start_when_idle, (i_start |-> (r_state == DIV_IDLE)),
        "divider started while busy")
    `BMR_ASSERT(a_rem_range, ((r_state == DIV_RUN) |-> (r_rem < {r_div, 1'b0})),
        "partial remainder out of range")
    `BMR_ASSERT(a_quot_bound, ((r_state == DIV_DONE) |-> (r_quot <= Q_ONE)),
        "similarity above one")

endmodule

### hdl/byte_match_ratio.sv
// Top level of the byte match ratio block: counters, serial divider, output register.
// Depends on bmr_pkg, bmr_count, bmr_div and assert_macros.svh.
//
//  channel  direction  handshake           payload
//  in       to block   i_valid / o_stall   i_byte_first, i_has_first, i_byte_second,
//                                          i_has_second, i_is_last
//  out      from block o_valid / i_stall   o_similarity, o_match_total, o_longer_length
//
// Positions are taken one per cycle while the divider is idle.
// The item marked last starts the divider, which makes one quotient bit per cycle.
// o_stall then stays high while the divider forms the quotient and hands it off,
// or only for the hand-off when either sequence is empty, longer while a result waits.
// The output register frees the divider while a result waits; i_stall holds it.
// Reset is synchronous, active low, and clears the match and length counters.
`include "assert_macros.svh"

module byte_match_ratio
    import bmr_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_byte_first,
    input  logic               i_has_first,
    input  logic [7:0]         i_byte_second,
    input  logic               i_has_second,
    input  logic               i_is_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [Q_BITS-1:0]  o_similarity,
    output logic [FIELD_W-1:0] o_match_total,
    output logic [FIELD_W-1:0] o_longer_length
);

    localparam int EXT_W = (LENGTH_BITS > FIELD_W) ? LENGTH_BITS : FIELD_W;

    logic                   accept;
    logic                   start;
    logic [LENGTH_BITS-1:0] cnt_match, cnt_first, cnt_second;
    t_div_stat              div_stat;
    logic                   take;
    logic [Q_BITS-1:0]      div_quot;
    logic [LENGTH_BITS-1:0] div_match, div_longer;
    logic [EXT_W-1:0]       match_ext, longer_ext;

    logic                   r_out_valid;
    logic [Q_BITS-1:0]      r_similarity;
    logic [FIELD_W-1:0]     r_match_total, r_longer_length;

    assign o_stall = div_stat.busy;
    assign accept  = i_valid && !o_stall;
    assign take    = div_stat.done && (!r_out_valid || !i_stall);

    bmr_count #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_count (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_byte_first  (i_byte_first),
        .i_has_first   (i_has_first),
        .i_byte_second (i_byte_second),
        .i_has_second  (i_has_second),
        .i_is_last     (i_is_last),
        .o_start       (start),
        .o_match       (cnt_match),
        .o_len_first   (cnt_first),
        .o_len_second  (cnt_second)
    );

    bmr_div #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_match      (cnt_match),
        .i_len_first  (cnt_first),
        .i_len_second (cnt_second),
        .i_take       (take),
        .o_stat       (div_stat),
        .o_quot       (div_quot),
        .o_match      (div_match),
        .o_longer     (div_longer)
    );

    // Counts wider than the port fields keep only their low bits.
    assign match_ext  = EXT_W'(div_match);
    assign longer_ext = EXT_W'(div_longer);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_similarity    <= div_quot;
            r_match_total   <= match_ext[FIELD_W-1:0];
            r_longer_length <= longer_ext[FIELD_W-1:0];
        end
    end

    assign o_valid         = r_out_valid;
    assign o_similarity    = r_similarity;
    assign o_match_total   = r_match_total;
    assign o_longer_length = r_longer_length;

    `BMR_IMPLY_NEXT(a_result_loaded, (div_stat.done && !r_out_valid), o_valid,
        "finished result not moved to the output register")

endmodule
